### hw/rtl/iwd_pkg.sv
package iwd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned OpW   = 6;
  localparam int unsigned RegW  = 7;
  localparam int unsigned ImmW  = 8;
  localparam int unsigned ModeW = 3;

  // Group codes, bits 15:12 of the word
  localparam logic [3:0] GRP_LPC    = 4'h0;
  localparam logic [3:0] GRP_SSP    = 4'h3;
  localparam logic [3:0] GRP_MEM    = 4'h4;
  localparam logic [3:0] GRP_MOV    = 4'h5;
  localparam logic [3:0] GRP_ALU    = 4'h6;
  localparam logic [3:0] GRP_SHIFT  = 4'h7;
  localparam logic [3:0] GRP_LLZ    = 4'h8;
  localparam logic [3:0] GRP_LH     = 4'hB;
  localparam logic [3:0] GRP_BRREL  = 4'hC;
  localparam logic [3:0] GRP_BRREG  = 4'hD;

  // Sub-operation codes
  localparam logic [3:0] SUB_MOV    = 4'h6;
  localparam logic [3:0] SUB_SWAP   = 4'hE;
  localparam logic [3:0] SUB_ALU_MAX = 4'hB;
  localparam logic [3:0] SUB_BR_MAX = 4'hB;
  localparam logic [3:0] SUB_CALL   = 4'hF;
  localparam logic [2:0] SUB_SH_BAD = 3'h7;
  localparam logic [WordW-1:0] WORD_HALT = 16'hFFFF;

  // Operation ids
  localparam logic [OpW-1:0] OP_UNKNOWN = 6'd0;
  localparam logic [OpW-1:0] OP_LPC     = 6'd1;
  localparam logic [OpW-1:0] OP_LDW     = 6'd5;
  localparam logic [OpW-1:0] OP_MOV     = 6'd6;
  localparam logic [OpW-1:0] OP_STW     = 6'd7;
  localparam logic [OpW-1:0] OP_SWAP    = 6'd8;
  localparam logic [OpW-1:0] OP_ALU     = 6'd9;
  localparam logic [OpW-1:0] OP_SHIFT   = 6'd21;
  localparam logic [OpW-1:0] OP_LLZ     = 6'd28;
  localparam logic [OpW-1:0] OP_BRANCH  = 6'd32;
  localparam logic [OpW-1:0] OP_CALL    = 6'd44;
  localparam logic [OpW-1:0] OP_HALT    = 6'd45;

  typedef struct packed {
    logic [OpW-1:0]   op_id;
    logic [RegW-1:0]  dest_reg;
    logic [RegW-1:0]  src_reg;
    logic [ImmW-1:0]  imm_value;
    logic [ImmW-1:0]  branch_offset;
    logic [WordW-1:0] target_addr;
    logic [ModeW-1:0] addr_mode;
    logic             shift_by_imm;
    logic             branch_by_reg;
  } dec_t;

endpackage

### hw/rtl/iwd_decode.sv
module iwd_decode (
  input  logic [iwd_pkg::WordW-1:0] word,
  input  logic [iwd_pkg::WordW-1:0] addr,
  output iwd_pkg::dec_t             dec
);
  import iwd_pkg::*;

  logic [3:0]       grp, hi, mid, lo;
  logic [7:0]       lsb;
  logic             add_en;
  logic             add_one;
  logic [WordW-1:0] add_op;

  assign grp = word[15:12];
  assign hi  = word[11:8];
  assign mid = word[7:4];
  assign lo  = word[3:0];
  assign lsb = word[7:0];

  always_comb begin
    dec     = '0;
    add_en  = 1'b0;
    add_one = 1'b0;
    add_op  = {8'h00, lsb};
    unique case (grp) inside
      [GRP_LPC:GRP_SSP]: begin
        dec.op_id     = OP_LPC + {2'b00, grp};
        dec.dest_reg  = {3'b000, hi};
        dec.imm_value = lsb;
        add_en        = 1'b1;
        add_one       = ~grp[0];   // lpc/spc are pc+1 relative
      end
      GRP_MEM: begin
        if (lo[2:0] <= 3'h4) begin
          dec.op_id     = lo[3] ? OP_STW : OP_LDW;
          dec.addr_mode = lo[2:0];
          dec.dest_reg  = {3'b000, hi};
          dec.src_reg   = {3'b000, mid};
        end else if (lo == SUB_MOV || lo == SUB_SWAP) begin
          dec.op_id    = (lo == SUB_MOV) ? OP_MOV : OP_SWAP;
          dec.dest_reg = {3'b000, hi};
          dec.src_reg  = {3'b000, mid};
        end
      end
      GRP_MOV: begin
        dec.op_id = OP_MOV;
        if (word[7]) begin
          dec.dest_reg = word[6:0];
          dec.src_reg  = {3'b000, hi};
        end else begin
          dec.dest_reg = {3'b000, hi};
          dec.src_reg  = word[6:0];
        end
      end
      GRP_ALU: begin
        if (lo <= SUB_ALU_MAX) begin
          dec.op_id    = OP_ALU + {2'b00, lo};
          dec.dest_reg = {3'b000, hi};
          dec.src_reg  = {3'b000, mid};
        end
      end
      GRP_SHIFT: begin
        if (lo[2:0] != SUB_SH_BAD) begin
          dec.op_id        = OP_SHIFT + {3'b000, lo[2:0]};
          dec.shift_by_imm = lo[3];
          dec.dest_reg     = {3'b000, hi};
          dec.src_reg      = {3'b000, mid};
        end
      end
      [GRP_LLZ:GRP_LH]: begin
        dec.op_id     = OP_LLZ + {4'h0, grp[1:0]};
        dec.dest_reg  = {3'b000, hi};
        dec.imm_value = lsb;
      end
      GRP_BRREL: begin
        if (hi <= SUB_BR_MAX) begin
          dec.op_id         = OP_BRANCH + {2'b00, hi};
          dec.branch_offset = lsb;
          add_en            = 1'b1;
          add_one           = 1'b1;
          add_op            = {{8{lsb[7]}}, lsb};
        end
      end
      GRP_BRREG: begin
        if (hi <= SUB_BR_MAX) begin
          dec.op_id         = OP_BRANCH + {2'b00, hi};
          dec.src_reg       = {3'b000, lo};
          dec.branch_by_reg = 1'b1;
        end else if (hi == SUB_CALL) begin
          dec.op_id         = OP_CALL;
          dec.dest_reg      = {3'b000, mid};
          dec.src_reg       = {3'b000, lo};
          dec.branch_by_reg = 1'b1;
        end
      end
      default: begin
        if (word == WORD_HALT) dec.op_id = OP_HALT;
      end
    endcase
    if (add_en) begin
      dec.target_addr = addr + add_op + {{(WordW-1){1'b0}}, add_one};
    end
  end

endmodule

### hw/rtl/instruction_word_decoder.sv
// Channel  | Signals                                        | Handshake
// ---------+------------------------------------------------+-----------------------
// command  | inst_word, inst_addr                           | start & !busy
// result   | op_id, dest_reg, src_reg, imm_value,           | done, one cycle
//          | branch_offset, target_addr, addr_mode,         |
//          | shift_by_imm, branch_by_reg                    |
//
// One transaction per clock; busy never rises, so start may be held every cycle.
// Input register, then decode and the 16-bit target adder into the result register;
// done is registered alongside the result register, so both appear together.
// Synchronous reset clears the valid pipeline only; no result is lost outside reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module instruction_word_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [iwd_pkg::WordW-1:0]    inst_word,
  input  logic [iwd_pkg::WordW-1:0]    inst_addr,
  output logic                         done,
  output logic [iwd_pkg::OpW-1:0]      op_id,
  output logic [iwd_pkg::RegW-1:0]     dest_reg,
  output logic [iwd_pkg::RegW-1:0]     src_reg,
  output logic [iwd_pkg::ImmW-1:0]     imm_value,
  output logic signed [iwd_pkg::ImmW-1:0] branch_offset,
  output logic [iwd_pkg::WordW-1:0]    target_addr,
  output logic [iwd_pkg::ModeW-1:0]    addr_mode,
  output logic                         shift_by_imm,
  output logic                         branch_by_reg
);
  import iwd_pkg::*;

  logic             vld;
  logic [WordW-1:0] word;
  logic [WordW-1:0] addr;
  dec_t             dec_next;
  dec_t             res;

  assign busy = 1'b0;

  iwd_decode u_decode (
    .word (word),
    .addr (addr),
    .dec  (dec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      done <= 1'b0;
    end else begin
      vld  <= start;
      done <= vld;
    end
    if (start) begin
      word <= inst_word;
      addr <= inst_addr;
    end
    if (vld) begin
      res <= dec_next;
    end
  end

  assign op_id         = res.op_id;
  assign dest_reg      = res.dest_reg;
  assign src_reg       = res.src_reg;
  assign imm_value     = res.imm_value;
  assign branch_offset = res.branch_offset;
  assign target_addr   = res.target_addr;
  assign addr_mode     = res.addr_mode;
  assign shift_by_imm  = res.shift_by_imm;
  assign branch_by_reg = res.branch_by_reg;

  a_done_follows_vld: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld))
    else $error("result strobe without a decoded transaction");

  a_unknown_clean: assert property (@(posedge clk) disable iff (rst)
    (done && op_id == OP_UNKNOWN) |-> (dest_reg == '0 && src_reg == '0 &&
      imm_value == '0 && target_addr == '0 && addr_mode == '0 &&
      !shift_by_imm && !branch_by_reg))
    else $error("unknown op carries nonzero fields");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(shift_by_imm && branch_by_reg))
    else $error("shift and register-branch flags both set");

  a_mode_only_mem: assert property (@(posedge clk) disable iff (rst)
    (done && addr_mode != '0) |-> (op_id == OP_LDW || op_id == OP_STW))
    else $error("addressing mode on a non load/store op");

endmodule

### dv/instruction_word_decoder_tb.sv
module instruction_word_decoder_tb;
  import iwd_pkg::*;

  // Codes not named in the package
  localparam logic [3:0] GRP_LSP       = 4'h1;
  localparam logic [3:0] GRP_SPC       = 4'h2;
  localparam logic [3:0] GRP_LHZ       = 4'h9;
  localparam logic [3:0] GRP_LL        = 4'hA;
  localparam logic [3:0] GRP_NONE      = 4'hE;
  localparam logic [3:0] GRP_TOP       = 4'hF;
  localparam logic [3:0] SUB_LDW_LAST  = 4'h4;
  localparam logic [3:0] SUB_STW_FIRST = 4'h8;
  localparam logic [3:0] SUB_STW_LAST  = 4'hC;
  localparam logic [3:0] SUB_MEM_HOLE  = 4'h5;
  localparam logic [3:0] SUB_MEM_TOP   = 4'hF;
  localparam logic [3:0] SUB_SH_IMM    = 4'h8;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned ReportMax    = 10;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [WordW-1:0] addr;
    dec_t             dec;
  } decode_rec_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [WordW-1:0]    inst_word;
  logic [WordW-1:0]    inst_addr;
  logic                done;
  logic [OpW-1:0]      op_id;
  logic [RegW-1:0]     dest_reg;
  logic [RegW-1:0]     src_reg;
  logic [ImmW-1:0]     imm_value;
  logic signed [ImmW-1:0] branch_offset;
  logic [WordW-1:0]    target_addr;
  logic [ModeW-1:0]    addr_mode;
  logic                shift_by_imm;
  logic                branch_by_reg;

  decode_rec_t pending_decodes[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;

  instruction_word_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .inst_word     (inst_word),
    .inst_addr     (inst_addr),
    .done          (done),
    .op_id         (op_id),
    .dest_reg      (dest_reg),
    .src_reg       (src_reg),
    .imm_value     (imm_value),
    .branch_offset (branch_offset),
    .target_addr   (target_addr),
    .addr_mode     (addr_mode),
    .shift_by_imm  (shift_by_imm),
    .branch_by_reg (branch_by_reg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic dec_t decode_word(input logic [WordW-1:0] w, input logic [WordW-1:0] a);
    dec_t       r;
    logic [3:0] grp;
    logic [3:0] hi;
    logic [3:0] mid;
    logic [3:0] lo;
    logic [7:0] low_byte;
    r = '0;
    grp = w[15:12];
    hi = w[11:8];
    mid = w[7:4];
    lo = w[3:0];
    low_byte = w[7:0];
    case (grp)
      GRP_LPC, GRP_LSP, GRP_SPC, GRP_SSP: begin
        r.op_id = OP_LPC + {2'b00, grp};
        r.dest_reg = {3'b000, hi};
        r.imm_value = low_byte;
        // pc-relative forms count from the next word, sp-relative ones do not
        r.target_addr = a + {8'h00, low_byte} +
                        ((grp == GRP_LPC || grp == GRP_SPC) ? 16'd1 : 16'd0);
      end
      GRP_MEM: begin
        if (lo <= SUB_LDW_LAST || (lo >= SUB_STW_FIRST && lo <= SUB_STW_LAST)) begin
          r.op_id = lo[3] ? OP_STW : OP_LDW;
          r.addr_mode = lo[2:0];
          r.dest_reg = {3'b000, hi};
          r.src_reg = {3'b000, mid};
        end else if (lo == SUB_MOV || lo == SUB_SWAP) begin
          r.op_id = (lo == SUB_MOV) ? OP_MOV : OP_SWAP;
          r.dest_reg = {3'b000, hi};
          r.src_reg = {3'b000, mid};
        end
      end
      GRP_MOV: begin
        r.op_id = OP_MOV;
        if (w[7]) begin
          r.dest_reg = w[6:0];
          r.src_reg = {3'b000, hi};
        end else begin
          r.dest_reg = {3'b000, hi};
          r.src_reg = w[6:0];
        end
      end
      GRP_ALU: begin
        if (lo <= SUB_ALU_MAX) begin
          r.op_id = OP_ALU + {2'b00, lo};
          r.dest_reg = {3'b000, hi};
          r.src_reg = {3'b000, mid};
        end
      end
      GRP_SHIFT: begin
        if (lo[2:0] != SUB_SH_BAD) begin
          r.op_id = OP_SHIFT + {3'b000, lo[2:0]};
          r.shift_by_imm = lo[3];
          r.dest_reg = {3'b000, hi};
          r.src_reg = {3'b000, mid};
        end
      end
      GRP_LLZ, GRP_LHZ, GRP_LL, GRP_LH: begin
        r.op_id = OP_LLZ + {2'b00, grp - GRP_LLZ};
        r.dest_reg = {3'b000, hi};
        r.imm_value = low_byte;
      end
      GRP_BRREL: begin
        if (hi <= SUB_BR_MAX) begin
          r.op_id = OP_BRANCH + {2'b00, hi};
          r.branch_offset = low_byte;
          r.target_addr = a + 16'd1 + {{8{low_byte[7]}}, low_byte};
        end
      end
      GRP_BRREG: begin
        if (hi <= SUB_BR_MAX) begin
          r.op_id = OP_BRANCH + {2'b00, hi};
          r.src_reg = {3'b000, lo};
          r.branch_by_reg = 1'b1;
        end else if (hi == SUB_CALL) begin
          r.op_id = OP_CALL;
          r.dest_reg = {3'b000, mid};
          r.src_reg = {3'b000, lo};
          r.branch_by_reg = 1'b1;
        end
      end
      default: begin
        if (w == WORD_HALT) r.op_id = OP_HALT;
      end
    endcase
    return r;
  endfunction

  // Record accepted commands and check results, both at the rising edge
  always @(posedge clk) begin
    decode_rec_t want;
    dec_t        got;
    if (!rst) begin
      if (done) begin
        got = '{op_id, dest_reg, src_reg, imm_value, branch_offset, target_addr,
                addr_mode, shift_by_imm, branch_by_reg};
        if (pending_decodes.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("unexpected result op=%0d at %0t", op_id, $realtime);
        end else begin
          want = pending_decodes.pop_front();
          if (got !== want.dec) begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("mismatch word=%h addr=%h", want.word, want.addr);
              $display({"  expected op=%0d dst=%0d src=%0d imm=%h off=%h tgt=%h",
                        " mode=%0d shi=%b br=%b"},
                       want.dec.op_id, want.dec.dest_reg, want.dec.src_reg,
                       want.dec.imm_value, want.dec.branch_offset, want.dec.target_addr,
                       want.dec.addr_mode, want.dec.shift_by_imm, want.dec.branch_by_reg);
              $display({"  actual   op=%0d dst=%0d src=%0d imm=%h off=%h tgt=%h",
                        " mode=%0d shi=%b br=%b"},
                       got.op_id, got.dest_reg, got.src_reg, got.imm_value,
                       got.branch_offset, got.target_addr, got.addr_mode,
                       got.shift_by_imm, got.branch_by_reg);
            end
          end
        end
      end
      if (start && !busy)
        pending_decodes.push_back('{inst_word, inst_addr, decode_word(inst_word, inst_addr)});
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WordW-1:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {8'hFF, 8'($urandom_range(0, 255))};
      default: return WordW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_cmd(input logic [WordW-1:0] word, input logic [WordW-1:0] addr);
    int unsigned gap;
    @(negedge clk);
    start <= 1'b1;
    inst_word <= word;
    inst_addr <= addr;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic test_pc_sp_relative();
    send_cmd({GRP_LPC, 4'hF, 8'hFF}, 16'hFFFF);
    send_cmd({GRP_LSP, 4'h0, 8'h00}, 16'h0000);
    send_cmd({GRP_SPC, 4'h5, 8'h80}, 16'hFF7F);
    send_cmd({GRP_SSP, 4'hA, 8'hFF}, 16'hFFFF);
  endtask

  task automatic test_memory_forms();
    send_cmd({GRP_MEM, 4'hF, 4'h0, SUB_LDW_LAST}, pick_addr());
    send_cmd({GRP_MEM, 4'h0, 4'hF, SUB_STW_FIRST}, pick_addr());
    send_cmd({GRP_MEM, 4'h9, 4'h6, SUB_STW_LAST}, pick_addr());
    send_cmd({GRP_MEM, 4'h3, 4'hC, SUB_MOV}, pick_addr());
    send_cmd({GRP_MEM, 4'hC, 4'h3, SUB_SWAP}, pick_addr());
    send_cmd({GRP_MEM, 4'hF, 4'hF, SUB_MEM_HOLE}, pick_addr());
    send_cmd({GRP_MEM, 4'hF, 4'hF, SUB_MEM_TOP}, pick_addr());
  endtask

  task automatic test_register_move();
    // bit 7 swaps which side gets the wide register field
    send_cmd({GRP_MOV, 4'hF, 1'b1, 7'h7F}, pick_addr());
    send_cmd({GRP_MOV, 4'h0, 1'b0, 7'h7F}, pick_addr());
    send_cmd({GRP_MOV, 4'hF, 1'b0, 7'h00}, pick_addr());
  endtask

  task automatic test_alu_shift();
    send_cmd({GRP_ALU, 4'hF, 4'h0, SUB_ALU_MAX}, pick_addr());
    send_cmd({GRP_ALU, 4'h1, 4'h2, SUB_ALU_MAX + 4'h1}, pick_addr());
    send_cmd({GRP_SHIFT, 4'h7, 4'hF, SUB_SH_IMM}, pick_addr());
    send_cmd({GRP_SHIFT, 4'h7, 4'hF, {1'b1, SUB_SH_BAD}}, pick_addr());
  endtask

  task automatic test_branches();
    send_cmd({GRP_BRREL, 4'h0, 8'h80}, 16'h0000);
    send_cmd({GRP_BRREL, SUB_BR_MAX, 8'h7F}, 16'hFFFF);
    send_cmd({GRP_BRREL, SUB_BR_MAX + 4'h1, 8'hFF}, pick_addr());
    send_cmd({GRP_BRREG, 4'h0, 4'hF, 4'hF}, pick_addr());
    send_cmd({GRP_BRREG, SUB_CALL, 4'hA, 4'h5}, pick_addr());
    send_cmd({GRP_BRREG, SUB_BR_MAX + 4'h2, 4'hF, 4'hF}, pick_addr());
  endtask

  task automatic test_unused_groups();
    send_cmd({GRP_NONE, 12'hFFF}, pick_addr());
    send_cmd({GRP_TOP, 12'hFFE}, 16'hFFFF);
    send_cmd(WORD_HALT, 16'hFFFF);
  endtask

  // Every group with every sub-operation code in both selector positions
  task automatic test_every_operation();
    logic [WordW-1:0] word;
    for (int g = 0; g < 16; g++) begin
      for (int c = 0; c < 16; c++) begin
        word = WordW'($urandom_range(0, 65535));
        word[15:12] = 4'(g);
        word[11:8] = 4'(c);
        word[3:0] = 4'(c);
        send_cmd(word, pick_addr());
      end
    end
  endtask

  task automatic test_random_words();
    logic [WordW-1:0] word;
    for (int n = 0; n < 400; n++) begin
      // stretches with no idling at all
      steady = (n % 100) >= 70;
      if (n == 200) drain();
      case ($urandom_range(0, 15))
        0: word = WORD_HALT;
        1: word = {GRP_TOP, 12'($urandom_range(0, 4095))};
        default: word = WordW'($urandom_range(0, 65535));
      endcase
      send_cmd(word, pick_addr());
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    inst_word = '0;
    inst_addr = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_pc_sp_relative();
    test_memory_forms();
    test_register_move();
    test_alu_shift();
    test_branches();
    test_unused_groups();
    test_every_operation();
    test_random_words();
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/iwd_pkg.sv
hw/rtl/iwd_decode.sv
hw/rtl/instruction_word_decoder.sv
dv/instruction_word_decoder_tb.sv
